FILE: hw/rtl/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Types, register codes and fixed-point helpers of the particle sort block.
// ----------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

  localparam int MaxParticles = 64;

  typedef struct packed {
    logic signed [31:0] loc_x;
    logic signed [31:0] loc_y;
    logic signed [31:0] loc_z;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic        [31:0] color_rgba;
    logic        [16:0] relative_time;
    logic        [30:0] lifetime;
    logic signed [31:0] rotation_rate;
    logic               last_particle;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_rotation;
    logic signed [31:0] out_size_x;
    logic signed [31:0] out_size_y;
    logic        [31:0] out_color;
    logic               out_last;
  } out_word_t;

  // one stored particle record
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] rotation;
    logic [31:0] size_x;
    logic [31:0] size_y;
    logic [31:0] color;
  } rec_t;

  typedef enum logic [2:0] {
    RegSortMode = 3'd0,
    RegScaleX   = 3'd1,
    RegScaleY   = 3'd2,
    RegScaleZ   = 3'd3,
    RegCameraX  = 3'd4,
    RegCameraY  = 3'd5,
    RegCameraZ  = 3'd6
  } reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul1,
    StMul2,
    StIns,
    StRead,
    StOut
  } state_e;

  typedef struct packed {
    logic insert;
    logic pop;
    logic clear;
  } cell_ctrl_t;

  localparam logic [1:0] ModeNone = 2'd0;
  localparam logic [1:0] ModeAge  = 2'd1;

  // floor a Q32.32-style product back to Q16.16 and saturate
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    logic signed [47:0] s;
    s = 48'(p >>> 16);
    if (s > 48'sh0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (s < -48'sh0000_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return s[31:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pds_calc.sv
// ----------------------------------------------------------------------------
// pds_calc
// Two-stage multiply datapath: scaled position, size, rotation and sort key.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_calc (
  input  wire logic               clk_i,
  input  wire logic               st1_en_i,
  input  wire logic               st2_en_i,
  input  wire pds_pkg::in_word_t  in_i,
  input  wire logic signed [31:0] scale_x_i,
  input  wire logic signed [31:0] scale_y_i,
  input  wire logic signed [31:0] scale_z_i,
  input  wire logic signed [31:0] cam_x_i,
  input  wire logic signed [31:0] cam_y_i,
  input  wire logic signed [31:0] cam_z_i,
  input  wire logic               mode_age_i,
  output pds_pkg::rec_t           rec_o,
  output logic [63:0]             key_o
);

  logic signed [31:0] px_q, py_q, pz_q, sx_q, sy_q, rrt_q, rot_q;
  logic [63:0] sqx_q, sqy_q, sqz_q;

  function automatic logic [31:0] absdiff(input logic signed [31:0] p,
                                          input logic signed [31:0] c);
    logic signed [32:0] d;
    logic [32:0] a;
    d = {p[31], p} - {c[31], c};
    a = d[32] ? 33'(-d) : 33'(d);
    return a[31:0];
  endfunction

  // stage 1: per-axis scale and rate times relative time
  always_ff @(posedge clk_i) begin
    if (st1_en_i) begin
      px_q  <= pds_pkg::qsat(64'(in_i.loc_x)  * 64'(scale_x_i));
      py_q  <= pds_pkg::qsat(64'(in_i.loc_y)  * 64'(scale_y_i));
      pz_q  <= pds_pkg::qsat(64'(in_i.loc_z)  * 64'(scale_z_i));
      sx_q  <= pds_pkg::qsat(64'(in_i.size_x) * 64'(scale_x_i));
      sy_q  <= pds_pkg::qsat(64'(in_i.size_y) * 64'(scale_y_i));
      rrt_q <= pds_pkg::qsat(64'(in_i.rotation_rate) *
                             64'($signed({15'd0, in_i.relative_time})));
    end
  end

  // stage 2: squared camera distance per axis, times lifetime
  always_ff @(posedge clk_i) begin
    if (st2_en_i) begin
      sqx_q <= 64'(absdiff(px_q, cam_x_i)) * 64'(absdiff(px_q, cam_x_i));
      sqy_q <= 64'(absdiff(py_q, cam_y_i)) * 64'(absdiff(py_q, cam_y_i));
      sqz_q <= 64'(absdiff(pz_q, cam_z_i)) * 64'(absdiff(pz_q, cam_z_i));
      rot_q <= pds_pkg::qsat(64'(rrt_q) * 64'($signed({1'b0, in_i.lifetime})));
    end
  end

  logic [64:0] sum_ab, sum_abc;
  logic [63:0] ab_sat;

  always_comb begin
    sum_ab  = {1'b0, sqx_q} + {1'b0, sqy_q};
    ab_sat  = sum_ab[64] ? '1 : sum_ab[63:0];
    sum_abc = {1'b0, ab_sat} + {1'b0, sqz_q};
    if (mode_age_i) begin
      key_o = {47'd0, in_i.relative_time};
    end else begin
      key_o = sum_abc[64] ? '1 : sum_abc[63:0];
    end
  end

  assign rec_o = '{pos_x: px_q, pos_y: py_q, pos_z: pz_q, rotation: rot_q,
                   size_x: sx_q, size_y: sy_q, color: in_i.color_rgba};

endmodule

`default_nettype wire

FILE: hw/rtl/pds_cell.sv
// ----------------------------------------------------------------------------
// pds_cell
// One cell of the sorted chain: a key and the slot index of its record.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_cell #(
  parameter int IdxW = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pds_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [63:0]          new_key_i,
  input  wire logic [IdxW-1:0]      new_idx_i,
  input  wire logic                 left_stay_i,
  input  wire logic                 left_valid_i,
  input  wire logic [63:0]          left_key_i,
  input  wire logic [IdxW-1:0]      left_idx_i,
  input  wire logic                 right_valid_i,
  input  wire logic [63:0]          right_key_i,
  input  wire logic [IdxW-1:0]      right_idx_i,
  output logic                      stay_o,
  output logic                      valid_o,
  output logic [63:0]               key_o,
  output logic [IdxW-1:0]           idx_o
);

  logic            valid_q;
  logic [63:0]     key_q;
  logic [IdxW-1:0] idx_q;

  // equal keys stay ahead of the newcomer
  assign stay_o = valid_q && (key_q >= new_key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.pop) begin
      valid_q <= right_valid_i;
    end else if (ctrl_i.insert && !stay_o) begin
      valid_q <= left_stay_i ? 1'b1 : left_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop) begin
      key_q <= right_key_i;
      idx_q <= right_idx_i;
    end else if (ctrl_i.insert && !stay_o) begin
      key_q <= left_stay_i ? new_key_i : left_key_i;
      idx_q <= left_stay_i ? new_idx_i : left_idx_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign idx_o   = idx_q;

endmodule

`default_nettype wire

FILE: hw/rtl/particle_depth_sort_gather.sv
// ----------------------------------------------------------------------------
// particle_depth_sort_gather
// Loads a batch of particles, scales them, and emits them in arrival, age or
// camera distance order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | word
//  in      | input     | in_valid_i / in_stall_o | pds_pkg::in_word_t
//  out     | output    | out_valid_o/ out_stall_i| pds_pkg::out_word_t
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
//  Loading a particle runs through two multiply stages, then a step that
//  writes the record memory and inserts the key into the cell chain.
//  Each emitted word is a registered memory read, then the word is held
//  until taken.
//  Reset empties the chain and the fill count; records need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_depth_sort_gather #(
  parameter int MAX_PARTICLES = pds_pkg::MaxParticles
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pds_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pds_pkg::out_word_t      out_word_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i
);

  localparam int IdxW = $clog2(MAX_PARTICLES);
  localparam int CntW = $clog2(MAX_PARTICLES + 1);

  pds_pkg::state_e state_q, state_d;
  logic [1:0]  mode_q;
  logic signed [31:0] scale_x_q, scale_y_q, scale_z_q, cam_x_q, cam_y_q, cam_z_q;
  pds_pkg::in_word_t in_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] rd_cnt_q;
  logic            last_q;
  logic            full;
  pds_pkg::rec_t   rec, rdata_q;
  pds_pkg::rec_t   mem_q [MAX_PARTICLES];
  logic [63:0]     new_key;
  pds_pkg::cell_ctrl_t ctrl;
  logic [IdxW-1:0] rd_addr;
  logic            st1_en, st2_en;

  logic            c_stay  [MAX_PARTICLES];
  logic            c_valid [MAX_PARTICLES];
  logic [63:0]     c_key   [MAX_PARTICLES];
  logic [IdxW-1:0] c_idx   [MAX_PARTICLES];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= pds_pkg::ModeNone;
      scale_x_q <= 32'sh0001_0000;
      scale_y_q <= 32'sh0001_0000;
      scale_z_q <= 32'sh0001_0000;
      cam_x_q   <= '0;
      cam_y_q   <= '0;
      cam_z_q   <= '0;
    end else if (cfg_we_i) begin
      case (pds_pkg::reg_e'(cfg_idx_i))
        pds_pkg::RegSortMode: mode_q    <= cfg_data_i[1:0];
        pds_pkg::RegScaleX:   scale_x_q <= cfg_data_i;
        pds_pkg::RegScaleY:   scale_y_q <= cfg_data_i;
        pds_pkg::RegScaleZ:   scale_z_q <= cfg_data_i;
        pds_pkg::RegCameraX:  cam_x_q   <= cfg_data_i;
        pds_pkg::RegCameraY:  cam_y_q   <= cfg_data_i;
        pds_pkg::RegCameraZ:  cam_z_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full = (count_q == CntW'(MAX_PARTICLES));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pds_pkg::StIdle: if (in_valid_i) state_d = pds_pkg::StMul1;
      pds_pkg::StMul1: state_d = pds_pkg::StMul2;
      pds_pkg::StMul2: state_d = pds_pkg::StIns;
      pds_pkg::StIns:  state_d = in_q.last_particle ? pds_pkg::StRead : pds_pkg::StIdle;
      pds_pkg::StRead: state_d = pds_pkg::StOut;
      pds_pkg::StOut: begin
        if (!out_stall_i) state_d = last_q ? pds_pkg::StIdle : pds_pkg::StRead;
      end
      default: state_d = pds_pkg::StIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o  = (state_q != pds_pkg::StIdle);
    out_valid_o = (state_q == pds_pkg::StOut);
    st1_en      = (state_q == pds_pkg::StMul1);
    st2_en      = (state_q == pds_pkg::StMul2);
    ctrl.insert = (state_q == pds_pkg::StIns) && !full;
    ctrl.pop    = (state_q == pds_pkg::StRead);
    ctrl.clear  = (state_q == pds_pkg::StOut) && !out_stall_i && last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pds_pkg::StIdle;
      count_q  <= '0;
      rd_cnt_q <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.clear) begin
        count_q <= '0;
      end else if (ctrl.insert) begin
        count_q <= count_q + CntW'(1);
      end
      if (state_q == pds_pkg::StIns) begin
        rd_cnt_q <= '0;
      end else if (state_q == pds_pkg::StOut && !out_stall_i) begin
        rd_cnt_q <= rd_cnt_q + IdxW'(1);
      end
      if (state_q == pds_pkg::StRead) begin
        last_q <= ((CntW'(rd_cnt_q) + CntW'(1)) == count_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  pds_calc u_calc (
    .clk_i      (clk_i),
    .st1_en_i   (st1_en),
    .st2_en_i   (st2_en),
    .in_i       (in_q),
    .scale_x_i  (scale_x_q),
    .scale_y_i  (scale_y_q),
    .scale_z_i  (scale_z_q),
    .cam_x_i    (cam_x_q),
    .cam_y_i    (cam_y_q),
    .cam_z_i    (cam_z_q),
    .mode_age_i (mode_q == pds_pkg::ModeAge),
    .rec_o      (rec),
    .key_o      (new_key)
  );

  // record memory, indexed by arrival slot
  assign rd_addr = (mode_q == pds_pkg::ModeNone) ? rd_cnt_q : c_idx[0];

  always_ff @(posedge clk_i) begin
    if (ctrl.insert) begin
      mem_q[count_q[IdxW-1:0]] <= rec;
    end
    if (state_q == pds_pkg::StRead) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // sorted chain, largest key at cell 0
  for (genvar g = 0; g < MAX_PARTICLES; g++) begin : g_cell
    logic            l_stay, l_valid, r_valid;
    logic [63:0]     l_key, r_key;
    logic [IdxW-1:0] l_idx, r_idx;

    if (g == 0) begin : g_head
      assign l_stay  = 1'b1;
      assign l_valid = 1'b0;
      assign l_key   = '0;
      assign l_idx   = '0;
    end else begin : g_body
      assign l_stay  = c_stay[g-1];
      assign l_valid = c_valid[g-1];
      assign l_key   = c_key[g-1];
      assign l_idx   = c_idx[g-1];
    end

    if (g == MAX_PARTICLES - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_key   = '0;
      assign r_idx   = '0;
    end else begin : g_inner
      assign r_valid = c_valid[g+1];
      assign r_key   = c_key[g+1];
      assign r_idx   = c_idx[g+1];
    end

    pds_cell #(.IdxW(IdxW)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_key_i     (new_key),
      .new_idx_i     (count_q[IdxW-1:0]),
      .left_stay_i   (l_stay),
      .left_valid_i  (l_valid),
      .left_key_i    (l_key),
      .left_idx_i    (l_idx),
      .right_valid_i (r_valid),
      .right_key_i   (r_key),
      .right_idx_i   (r_idx),
      .stay_o        (c_stay[g]),
      .valid_o       (c_valid[g]),
      .key_o         (c_key[g]),
      .idx_o         (c_idx[g])
    );
  end

  assign out_word_o = '{out_pos_x:    rdata_q.pos_x,
                        out_pos_y:    rdata_q.pos_y,
                        out_pos_z:    rdata_q.pos_z,
                        out_rotation: rdata_q.rotation,
                        out_size_x:   rdata_q.size_x,
                        out_size_y:   rdata_q.size_y,
                        out_color:    rdata_q.color,
                        out_last:     last_q};

endmodule

`default_nettype wire
